// ----- rtl/rbf_pkg.sv -----
// Shared constants, codes and types of the raster block framer.
package rbf_pkg;

	localparam int MAX_BLOCK = 60;
	localparam int PAGE_MAX  = 8192;

	localparam int BLK_W  = 6;
	localparam int PAGE_W = 14;
	localparam int CFG_W  = 14;
	localparam int IDX_W  = 2;
	localparam int STEP_W = 4;

	// The 64-byte frame is eight rows of eight byte lanes, one lane RAM per lane.
	localparam int LANES     = 8;
	localparam int ROW_W     = 3;
	localparam int BANKS     = 2;
	localparam int RAM_DEPTH = BANKS * (1 << ROW_W);
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	localparam int HDR_BYTES = 4;

	localparam logic [7:0] HDR_START  = 8'h02;
	localparam logic [7:0] HDR_RASTER = 8'hFE;
	localparam logic [7:0] HDR_PAD    = 8'h00;
	localparam logic [7:0] HDR_END    = 8'h04;
	localparam logic [7:0] CMD_PRINT  = 8'h0C;

	localparam logic [IDX_W-1:0] REG_BLOCK_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_PAGE_LIMIT  = 2'd1;

	localparam logic [1:0] KIND_BLOCK = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_PAGE  = 2'd2;

	// Back-end sequence steps: 0..7 are the block rows.
	localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_LAST_DATA = 4'd7;
	localparam logic [STEP_W-1:0] STEP_END0      = 4'd8;
	localparam logic [STEP_W-1:0] STEP_END1      = 4'd9;
	localparam logic [STEP_W-1:0] STEP_PAGE      = 4'd10;

	localparam logic [3:0] COUNT_FULL  = 4'd8;
	localparam logic [3:0] COUNT_PRINT = 4'd1;

	// One closed block handed from front to back.
	typedef struct packed {
		logic [BLK_W-1:0] count;
		logic             last;
		logic             page;
		logic             bank;
	} cmd_t;

	// One byte write into the lane RAMs.
	typedef struct packed {
		logic [LANES-1:0]  lane_we;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} byte_wr_t;

endpackage

// ----- rtl/rbf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/rbf_cmd_fifo.sv -----
// Two-entry queue of closed-block commands between front and back.
module rbf_cmd_fifo import rbf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] used_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (used_q == 2'd2);
	assign head_valid = (used_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   used_q <= used_q + 2'd1;
				2'b01:   used_q <= used_q - 2'd1;
				default: used_q <= used_q;
			endcase
		end
	end

endmodule

// ----- rtl/rbf_front.sv -----
// Front end: limit registers, byte intake into the lane RAMs, block closing.
module rbf_front import rbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [BANKS-1:0]  bank_release,
	input  logic              cmd_full,
	output logic              cmd_push,
	output cmd_t              cmd,
	output byte_wr_t          byte_wr
);

	logic [BLK_W-1:0]  block_limit_q;
	logic [PAGE_W-1:0] page_limit_q;
	logic [BLK_W-1:0]  block_fill_q;
	logic [PAGE_W-1:0] page_fill_q;
	logic              wr_bank_q;
	logic [BANKS-1:0]  bank_busy_q;

	logic [BLK_W-1:0]  blim;
	logic [PAGE_W-1:0] plim;
	logic [BLK_W-1:0]  fill;
	logic [BLK_W-1:0]  fill_next;
	logic [BLK_W-1:0]  pos;
	logic [PAGE_W-1:0] page_next;
	logic              page_end;
	logic              close;
	logic              accept;

	// Out-of-range limits act as the maximum.
	assign blim = (block_limit_q == '0 || block_limit_q > BLK_W'(MAX_BLOCK)) ?
		BLK_W'(MAX_BLOCK) : block_limit_q;
	assign plim = (page_limit_q == '0 || page_limit_q > PAGE_W'(PAGE_MAX)) ?
		PAGE_W'(PAGE_MAX) : page_limit_q;

	assign in_stall = bank_busy_q[wr_bank_q] || cmd_full;
	assign accept   = in_valid && !in_stall;

	assign fill      = (block_fill_q >= BLK_W'(MAX_BLOCK)) ?
		BLK_W'(MAX_BLOCK - 1) : block_fill_q;
	assign fill_next = fill + BLK_W'(1);
	assign pos       = fill + BLK_W'(HDR_BYTES);
	assign page_next = page_fill_q + PAGE_W'(1);
	assign page_end  = (page_next >= plim);
	assign close     = (fill_next >= blim) || page_end || last_byte;

	// Byte at frame position pos lands in lane pos%8, row pos/8 of the open bank.
	assign byte_wr.lane_we = accept ? (LANES'(1) << pos[ROW_W-1:0]) : '0;
	assign byte_wr.addr    = {wr_bank_q, pos[BLK_W-1:ROW_W]};
	assign byte_wr.data    = data_byte;

	assign cmd_push   = accept && close;
	assign cmd.count  = fill_next;
	assign cmd.last   = last_byte;
	assign cmd.page   = page_end || last_byte;
	assign cmd.bank   = wr_bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_limit_q <= BLK_W'(MAX_BLOCK);
			page_limit_q  <= PAGE_W'(PAGE_MAX);
			block_fill_q  <= '0;
			page_fill_q   <= '0;
			wr_bank_q     <= 1'b0;
			bank_busy_q   <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_BLOCK_LIMIT: block_limit_q <= wr_data[BLK_W-1:0];
					REG_PAGE_LIMIT:  page_limit_q  <= wr_data[PAGE_W-1:0];
					default:         ;
				endcase
			end
			if (accept) begin
				block_fill_q <= close ? '0 : fill_next;
				page_fill_q  <= (page_end || last_byte) ? '0 : page_next;
				if (close) begin
					wr_bank_q <= !wr_bank_q;
				end
			end
			// Hold the closed bank until the back end has read it out.
			bank_busy_q <= (bank_busy_q & ~bank_release) |
				(cmd_push ? (BANKS'(1) << wr_bank_q) : '0);
		end
	end

endmodule

// ----- rtl/rbf_back.sv -----
// Back end: steps through each closed block and emits its transfer words.
module rbf_back import rbf_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  cmd_t                        cmd,
	output logic                        cmd_pop,
	output logic [BANKS-1:0]            bank_release,
	output logic                        rd_en,
	output logic [RAM_AW-1:0]           rd_addr,
	input  logic [LANES-1:0][7:0]       rd_bytes,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [63:0]                 out_word,
	output logic [3:0]                  byte_count,
	output logic [1:0]                  transfer_kind,
	output logic                        transfer_end,
	output logic                        run_last
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	logic              final_step;
	logic              issue;
	logic              out_adv;

	logic              valid_s1;
	logic [STEP_W-1:0] step_s1;
	logic [BLK_W-1:0]  count_s1;
	logic              final_s1;

	logic              out_valid_q;
	logic [63:0]       word_q;
	logic [3:0]        count_q;
	logic [1:0]        kind_q;
	logic              end_q;
	logic              last_q;

	logic [63:0]       word_d;
	logic [1:0]        kind_d;
	logic              end_d;

	assign out_adv = !out_valid_q || !out_stall;
	assign issue   = cmd_valid && (!valid_s1 || out_adv);

	assign final_step = (step_q == STEP_LAST_DATA && !cmd.last && !cmd.page) ||
		(step_q == STEP_PAGE);

	always_comb begin
		case (step_q)
			STEP_LAST_DATA: step_next = cmd.last ? STEP_END0 : STEP_PAGE;
			STEP_END0:      step_next = STEP_END1;
			STEP_END1:      step_next = STEP_PAGE;
			default:        step_next = step_q + STEP_W'(1);
		endcase
	end

	assign rd_en        = issue && (step_q < STEP_END0);
	assign rd_addr      = {cmd.bank, step_q[ROW_W-1:0]};
	assign cmd_pop      = issue && final_step;
	assign bank_release = cmd_pop ? (BANKS'(1) << cmd.bank) : '0;

	// Assemble one word: header, block data, then zero padding, or a fixed raster-end or print-page word.
	always_comb begin
		logic [BLK_W-1:0] pos;
		logic [BLK_W:0]   data_end;
		word_d   = '0;
		data_end = {1'b0, count_s1} + (BLK_W + 1)'(HDR_BYTES);
		for (int b = 0; b < LANES; b++) begin
			pos = {step_s1[ROW_W-1:0], 3'(b)};
			if (pos < BLK_W'(HDR_BYTES)) begin
				case (pos[1:0])
					2'd0:    word_d[b*8 +: 8] = HDR_START;
					2'd1:    word_d[b*8 +: 8] = HDR_RASTER;
					2'd2:    word_d[b*8 +: 8] = 8'(count_s1);
					default: word_d[b*8 +: 8] = HDR_PAD;
				endcase
			end else if ({1'b0, pos} < data_end) begin
				word_d[b*8 +: 8] = rd_bytes[b];
			end
		end
		case (step_s1)
			STEP_END0: word_d = {48'h0, HDR_END, HDR_START};
			STEP_END1: word_d = '0;
			STEP_PAGE: word_d = {56'h0, CMD_PRINT};
			default:   ;
		endcase
	end

	always_comb begin
		case (step_s1)
			STEP_END0: kind_d = KIND_END;
			STEP_END1: kind_d = KIND_END;
			STEP_PAGE: kind_d = KIND_PAGE;
			default:   kind_d = KIND_BLOCK;
		endcase
	end

	assign end_d = (step_s1 == STEP_LAST_DATA) || (step_s1 == STEP_END1) ||
		(step_s1 == STEP_PAGE);

	always_ff @(posedge clk) begin
		if (issue) begin
			step_s1  <= step_q;
			count_s1 <= cmd.count;
			final_s1 <= final_step;
		end
		if (valid_s1 && out_adv) begin
			word_q  <= word_d;
			count_q <= (step_s1 == STEP_PAGE) ? COUNT_PRINT : COUNT_FULL;
			kind_q  <= kind_d;
			end_q   <= end_d;
			last_q  <= final_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_FIRST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				step_q <= final_step ? STEP_FIRST : step_next;
			end
			// Hold stage 1 (and the RAM read data) while the output is stalled.
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_word      = word_q;
	assign byte_count    = count_q;
	assign transfer_kind = kind_q;
	assign transfer_end  = end_q;
	assign run_last      = last_q;

endmodule

// ----- rtl/raster_block_framer.sv -----
// Raster block framer top level: intake, command queue, lane RAMs and word output.
//
// Input channel: one raster byte per item (data_byte, last_byte), in_valid/in_stall.
// Output channel: one 64-bit transfer word per item, out_valid/out_stall.
// Limits are written through wr_en/wr_index/wr_data only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// Bytes are taken one per cycle while in_stall is low and written into one of two
// frame banks. A byte that closes a block queues a command, and the back end sends
// 8 block words, then 2 raster-end words on the last byte, then 1 print-page word
// at a page or job end: 8 to 11 words, one per cycle while out_stall is low, the
// first word going through stage 1 and the output register once the command is
// queued. While one bank is being read out the other fills; input stalls only when
// both banks wait for the back end, e.g. with short blocks, where the rate is set
// by the 8 to 11 output words per closed block.
// Reset clears the fill counts and the queue and sets the limits to 60 and 8192;
// the frame RAMs need no clearing. A stalled output word holds, and the stall
// backs up through the queue into in_stall.
module raster_block_framer import rbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [63:0]       out_word,
	output logic [3:0]        byte_count,
	output logic [1:0]        transfer_kind,
	output logic              transfer_end,
	output logic              run_last
);

	cmd_t                  push_cmd;
	cmd_t                  head_cmd;
	logic                  cmd_push;
	logic                  cmd_full;
	logic                  cmd_pop;
	logic                  head_valid;
	logic [BANKS-1:0]      bank_release;
	byte_wr_t              byte_wr;
	logic                  rd_en;
	logic [RAM_AW-1:0]     rd_addr;
	logic [LANES-1:0][7:0] rd_bytes;

	rbf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.bank_release (bank_release),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd          (push_cmd),
		.byte_wr      (byte_wr)
	);

	rbf_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (push_cmd),
		.full       (cmd_full),
		.pop        (cmd_pop),
		.head_valid (head_valid),
		.head       (head_cmd)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		rbf_ram #(
			.WIDTH (8),
			.DEPTH (RAM_DEPTH)
		) u_lane_ram (
			.clk   (clk),
			.we    (byte_wr.lane_we[g]),
			.waddr (byte_wr.addr),
			.wdata (byte_wr.data),
			.re    (rd_en),
			.raddr (rd_addr),
			.rdata (rd_bytes[g])
		);
	end

	rbf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (head_valid),
		.cmd           (head_cmd),
		.cmd_pop       (cmd_pop),
		.bank_release  (bank_release),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_bytes      (rd_bytes),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_word      (out_word),
		.byte_count    (byte_count),
		.transfer_kind (transfer_kind),
		.transfer_end  (transfer_end),
		.run_last      (run_last)
	);

endmodule

// ----- rtl/rbf_checker.sv -----
// Port-level checks on the framer output channel, bound to the top level.
module rbf_checker import rbf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [63:0]       out_word,
	input logic [3:0]        byte_count,
	input logic [1:0]        transfer_kind,
	input logic              transfer_end,
	input logic              run_last
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(run_last))
		else $error("stalled output item changed");

	// Print page is a single one-byte word and always ends the run.
	a_print_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_kind == KIND_PAGE |->
			byte_count == COUNT_PRINT && transfer_end && run_last)
		else $error("print-page item malformed");

	// Block and raster-end words carry eight bytes.
	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_kind != KIND_PAGE |-> byte_count == COUNT_FULL)
		else $error("block or raster-end item not eight bytes");

	// A run never ends inside a transfer.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last |-> transfer_end)
		else $error("run ended inside a transfer");

endmodule

bind raster_block_framer rbf_checker u_rbf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_word      (out_word),
	.byte_count    (byte_count),
	.transfer_kind (transfer_kind),
	.transfer_end  (transfer_end),
	.run_last      (run_last)
);
